// ===== src/pdpmc_pkg.sv =====
// Package for the PD position motor controller.
// Holds the request codes, register map, configuration and result types shared by all modules.
// No dependencies.
package pdpmc_pkg;

    // Request kinds carried on the input tuser.
    typedef enum logic [1:0] {
        REQ_DELTA = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_START = 2'd2,
        REQ_ZERO  = 2'd3
    } t_req;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_SETPOINT  = 2'd0,
        REG_GAIN_P    = 2'd1,
        REG_GAIN_D    = 2'd2,
        REG_MIN_DRIVE = 2'd3
    } t_reg_idx;

    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [15:0] MIN_DRIVE_RESET = 16'd1400;
    localparam logic [15:0] DUTY_MAX = 16'hFFFF;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned RESULT_W    = 83;
    localparam int unsigned OUT_TDATA_W = 88;

    // Live configuration register values.
    typedef struct packed {
        logic signed [15:0] setpoint;
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_d;
        logic        [15:0] min_drive;
    } t_cfg;

    // Outcome of one running control tick.
    typedef struct packed {
        logic signed [16:0] err;
        logic        [31:0] torque;
        logic               run;
        logic               dir;
        logic        [15:0] duty;
    } t_tick_res;

    // One result item, first field in the highest bits.
    typedef struct packed {
        logic        [31:0] signed_torque;
        logic signed [16:0] last_err;
        logic signed [15:0] position;
        logic               running;
        logic               reverse_dir;
        logic        [15:0] pwm_duty;
    } t_result;

endpackage

// ===== src/pdpmc_cfg_regs.sv =====
// APB-style configuration register file for the PD position motor controller.
// Depends on pdpmc_pkg for the register map and configuration struct.
module pdpmc_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pdpmc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [pdpmc_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [pdpmc_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready,
    output pdpmc_pkg::t_cfg                     o_cfg
);

    pdpmc_pkg::t_cfg      r_cfg;
    pdpmc_pkg::t_reg_idx  reg_idx;
    logic                 wr_en;
    logic [15:0]          rd_val;

    assign pready  = 1'b1;
    assign reg_idx = pdpmc_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite & pready;

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint  <= '0;
            r_cfg.gain_p    <= '0;
            r_cfg.gain_d    <= '0;
            r_cfg.min_drive <= pdpmc_pkg::MIN_DRIVE_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                pdpmc_pkg::REG_SETPOINT:  r_cfg.setpoint  <= pwdata[15:0];
                pdpmc_pkg::REG_GAIN_P:    r_cfg.gain_p    <= pwdata[15:0];
                pdpmc_pkg::REG_GAIN_D:    r_cfg.gain_d    <= pwdata[15:0];
                pdpmc_pkg::REG_MIN_DRIVE: r_cfg.min_drive <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register, zero extended.
    always_comb begin
        unique case (reg_idx)
            pdpmc_pkg::REG_SETPOINT:  rd_val = r_cfg.setpoint;
            pdpmc_pkg::REG_GAIN_P:    rd_val = r_cfg.gain_p;
            pdpmc_pkg::REG_GAIN_D:    rd_val = r_cfg.gain_d;
            pdpmc_pkg::REG_MIN_DRIVE: rd_val = r_cfg.min_drive;
            default:                  rd_val = '0;
        endcase
    end

    assign prdata = {16'd0, rd_val};
    assign o_cfg  = r_cfg;

endmodule

// ===== src/pdpmc_tick_calc.sv =====
// Control law for one running tick: error, PD torque, direction and clamped duty.
// Depends on pdpmc_pkg for the configuration and tick result structs.
module pdpmc_tick_calc (
    input  pdpmc_pkg::t_cfg         i_cfg,
    input  logic signed [15:0]      i_position,
    input  logic signed [16:0]      i_prev_err,
    output pdpmc_pkg::t_tick_res    o_res
);

    logic signed [15:0] setpoint;
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_d;
    logic signed [16:0] err;
    logic signed [17:0] diff;
    logic signed [32:0] p_term;
    logic signed [33:0] d_term;
    logic        [31:0] torque_raw;
    logic        [31:0] torque;
    logic        [31:0] mag_full;
    logic        [15:0] mag_sat;
    logic               at_target;

    assign setpoint = i_cfg.setpoint;
    assign gain_p   = i_cfg.gain_p;
    assign gain_d   = i_cfg.gain_d;

    // Error and its change since the previous running tick.
    assign err  = 17'(setpoint) - 17'(i_position);
    assign diff = 18'(err) - 18'(i_prev_err);

    // Two products, combined modulo 2^32.
    assign p_term     = gain_p * err;
    assign d_term     = gain_d * diff;
    assign torque_raw = p_term[31:0] - d_term[31:0];

    // Reaching the target stops the run and drops the torque.
    assign at_target = (err == 17'sd0);
    assign torque    = at_target ? 32'd0 : torque_raw;

    // Magnitude, saturation, then the minimum drive while still running.
    assign mag_full = torque[31] ? (32'd0 - torque) : torque;
    assign mag_sat  = (|mag_full[31:16]) ? pdpmc_pkg::DUTY_MAX : mag_full[15:0];

    always_comb begin
        o_res.err    = err;
        o_res.torque = torque;
        o_res.run    = !at_target;
        o_res.dir    = torque[31];
        o_res.duty   = (!at_target && (mag_sat < i_cfg.min_drive)) ? i_cfg.min_drive
                                                                   : mag_sat;
    end

endmodule

// ===== src/pdpmc_core.sv =====
// Controller state and per-request update for the PD position motor controller.
// Depends on pdpmc_pkg and pdpmc_tick_calc.
module pdpmc_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  pdpmc_pkg::t_req         i_req,
    input  logic signed [7:0]       i_delta,
    input  pdpmc_pkg::t_cfg         i_cfg,
    output pdpmc_pkg::t_result      o_result
);

    logic signed [15:0]     r_pos;
    logic signed [16:0]     r_prev_err;
    logic                   r_run;
    logic        [15:0]     r_duty;
    logic                   r_dir;
    logic        [31:0]     r_torque;
    logic signed [16:0]     r_err;

    logic signed [15:0]     n_pos;
    logic signed [16:0]     n_prev_err;
    logic                   n_run;
    logic        [15:0]     n_duty;
    logic                   n_dir;
    logic        [31:0]     n_torque;
    logic signed [16:0]     n_err;

    pdpmc_pkg::t_tick_res   tick_res;

    pdpmc_tick_calc u_tick_calc (
        .i_cfg      (i_cfg),
        .i_position (r_pos),
        .i_prev_err (r_prev_err),
        .o_res      (tick_res)
    );

    // Next state for the request being processed.
    always_comb begin
        n_pos      = r_pos;
        n_prev_err = r_prev_err;
        n_run      = r_run;
        n_duty     = r_duty;
        n_dir      = r_dir;
        n_torque   = r_torque;
        n_err      = r_err;
        unique case (i_req)
            pdpmc_pkg::REQ_DELTA: n_pos = r_pos + 16'(i_delta);
            pdpmc_pkg::REQ_TICK: begin
                // A tick while stopped leaves everything as it is.
                if (r_run) begin
                    n_prev_err = tick_res.err;
                    n_err      = tick_res.err;
                    n_run      = tick_res.run;
                    n_duty     = tick_res.duty;
                    n_dir      = tick_res.dir;
                    n_torque   = tick_res.torque;
                end
            end
            pdpmc_pkg::REQ_START: n_run = 1'b1;
            pdpmc_pkg::REQ_ZERO:  n_pos = '0;
            default: ;
        endcase
    end

    // State advances once per processed transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_prev_err <= '0;
            r_run      <= 1'b0;
            r_duty     <= '0;
            r_dir      <= 1'b0;
            r_torque   <= '0;
            r_err      <= '0;
        end else if (i_fire) begin
            r_pos      <= n_pos;
            r_prev_err <= n_prev_err;
            r_run      <= n_run;
            r_duty     <= n_duty;
            r_dir      <= n_dir;
            r_torque   <= n_torque;
            r_err      <= n_err;
        end
    end

    // The result shows the state after this request.
    always_comb begin
        o_result.signed_torque = n_torque;
        o_result.last_err      = n_err;
        o_result.position      = n_pos;
        o_result.running       = n_run;
        o_result.reverse_dir   = n_dir;
        o_result.pwm_duty      = n_duty;
    end

endmodule

// ===== src/pd_position_motor_controller_top.sv =====
// Top level of the PD position motor controller: stream ports, input and result registers.
// Depends on pdpmc_pkg, pdpmc_cfg_regs and pdpmc_core.
//
//  Port group   Direction  Carries
//  s_axis       in         one request: tuser = req_type, tdata = encoder_delta
//  m_axis       out        one result per request (state after the request)
//  APB          in/out     setpoint, gain_p, gain_d, min_drive at 0x0, 0x4, 0x8, 0xC
//
// A request is captured in the input register, processed by the controller update (two
// multipliers of the tick path), and shown in the result register. One request per cycle
// is sustained while the result is not stalled. A stalled result holds the pipeline; the
// input register still takes a request while it is empty. Reset is synchronous and clears
// all controller state to stopped, zero position and zero drive, with min_drive at 1400.
module pd_position_motor_controller_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Slave stream. tdata: [7:0] encoder_delta. tuser: [1:0] req_type.
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [pdpmc_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    input  logic [pdpmc_pkg::IN_TUSER_W-1:0]        s_axis_tuser,
    // Master stream. tdata: [15:0] pwm_duty, [16] reverse_dir, [17] running,
    // [33:18] position, [50:34] last_err, [82:51] signed_torque, [87:83] zero.
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [pdpmc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // Configuration port.
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [pdpmc_pkg::CFG_ADDR_W-1:0]        paddr,
    input  logic [pdpmc_pkg::CFG_DATA_W-1:0]        pwdata,
    output logic [pdpmc_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                    pready
);

    pdpmc_pkg::t_cfg        cfg;
    pdpmc_pkg::t_result     result;

    logic                   r_in_valid;
    pdpmc_pkg::t_req        r_in_req;
    logic signed [7:0]      r_in_delta;
    logic                   r_out_valid;
    pdpmc_pkg::t_result     r_out_data;

    logic                   advance;
    logic                   fire;

    pdpmc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pdpmc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_req    (r_in_req),
        .i_delta  (r_in_delta),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // The result register frees up when empty or when its transaction completes.
    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    // Valid flags of the two pipeline registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_req   <= pdpmc_pkg::t_req'(s_axis_tuser);
            r_in_delta <= s_axis_tdata;
        end
        if (fire) begin
            r_out_data <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_data};

endmodule

// ===== src/pdpmc_checker.sv =====
// Port-level checker for the PD position motor controller, bound to the top level.
// Depends on pdpmc_pkg for widths only.
module pdpmc_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    input  logic [pdpmc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

    logic [15:0] duty;
    logic        rev;
    logic        run;
    logic [16:0] err;
    logic [31:0] torque;

    assign duty   = m_axis_tdata[15:0];
    assign rev    = m_axis_tdata[16];
    assign run    = m_axis_tdata[17];
    assign err    = m_axis_tdata[50:34];
    assign torque = m_axis_tdata[82:51];

    // A stalled result transaction keeps its data.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A stopped controller drives nothing.
    a_stopped_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !run |-> duty == 16'd0 && torque == 32'd0 && !rev)
        else $error("drive present while stopped");

    // Direction follows the sign of the torque.
    a_dir_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> rev == torque[31])
        else $error("direction disagrees with torque sign");

    // Nonzero torque only comes from a nonzero error.
    a_torque_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && torque != 32'd0 |-> err != 17'd0)
        else $error("torque without error");

endmodule

bind pd_position_motor_controller_top pdpmc_checker u_pdpmc_checker (.*);

// ===== sim/tb_pd_position_motor_controller_top.sv =====
// Self-checking testbench for the PD position motor controller top level.
// Drives request transactions and APB register writes, and checks every result against a
// built-in controller model or the table. Depends on pdpmc_pkg and the top-level RTL.
module tb_pd_position_motor_controller_top;
    timeunit 1ns;
    timeprecision 1ps;

    // One row of the directed stimulus: either a register write or a request.
    typedef struct {
        bit                   is_cfg;
        pdpmc_pkg::t_reg_idx  reg_idx;
        logic [15:0]          value;
        pdpmc_pkg::t_req      req;
        logic [7:0]           delta;
        bit                   typed;
        pdpmc_pkg::t_result   exp_res;
    } t_plan_row;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [pdpmc_pkg::IN_TDATA_W-1:0]    s_axis_tdata = '0;
    logic [pdpmc_pkg::IN_TUSER_W-1:0]    s_axis_tuser = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [pdpmc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [pdpmc_pkg::CFG_ADDR_W-1:0]    paddr = '0;
    logic [pdpmc_pkg::CFG_DATA_W-1:0]    pwdata = '0;
    logic [pdpmc_pkg::CFG_DATA_W-1:0]    prdata;
    logic                                pready;

    // Controller model state and its copy of the registers.
    pdpmc_pkg::t_cfg    mdl_cfg = '{setpoint: 16'sd0, gain_p: 16'sd0, gain_d: 16'sd0,
                                    min_drive: pdpmc_pkg::MIN_DRIVE_RESET};
    logic signed [15:0] mdl_pos = '0;
    logic signed [16:0] mdl_prev_err = '0;
    logic signed [16:0] mdl_err = '0;
    logic               mdl_run = 1'b0;
    logic               mdl_dir = 1'b0;
    logic [15:0]        mdl_duty = '0;
    logic [31:0]        mdl_torque = '0;

    pdpmc_pkg::t_result expected_results[$];
    int                 mismatch_count = 0;
    t_plan_row          plan[$];

    pd_position_motor_controller_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Free-running 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Advances the controller model by one request and returns the state it leaves.
    function automatic pdpmc_pkg::t_result step_controller(pdpmc_pkg::t_req req,
                                                           logic [7:0] delta);
        longint   err;
        longint   diff;
        longint   pterm;
        longint   dterm;
        logic [31:0] trq;
        logic [31:0] mag;
        pdpmc_pkg::t_result r;
        case (req)
            pdpmc_pkg::REQ_DELTA: mdl_pos = mdl_pos + {{8{delta[7]}}, delta};
            pdpmc_pkg::REQ_TICK: begin
                if (mdl_run) begin
                    err   = longint'(mdl_cfg.setpoint) - longint'(mdl_pos);
                    diff  = err - longint'(mdl_prev_err);
                    pterm = longint'(mdl_cfg.gain_p) * err;
                    dterm = longint'(mdl_cfg.gain_d) * diff;
                    trq   = pterm[31:0] - dterm[31:0];
                    mdl_prev_err = err[16:0];
                    // Reaching the setpoint ends the run with no torque.
                    if (err == 0) begin
                        mdl_run = 1'b0;
                        trq = '0;
                    end
                    mdl_err    = err[16:0];
                    mdl_torque = trq;
                    if (trq[31]) begin
                        mag = -trq;
                        mdl_dir = 1'b1;
                    end else begin
                        mag = trq;
                        mdl_dir = 1'b0;
                    end
                    if (mag > {16'h0, pdpmc_pkg::DUTY_MAX})
                        mag = {16'h0, pdpmc_pkg::DUTY_MAX};
                    if (mag < {16'h0, mdl_cfg.min_drive} && mdl_run)
                        mag = {16'h0, mdl_cfg.min_drive};
                    mdl_duty = mag[15:0];
                end
            end
            pdpmc_pkg::REQ_START: mdl_run = 1'b1;
            pdpmc_pkg::REQ_ZERO:  mdl_pos = '0;
        endcase
        r.pwm_duty      = mdl_duty;
        r.reverse_dir   = mdl_dir;
        r.running       = mdl_run;
        r.position      = mdl_pos;
        r.last_err      = mdl_err;
        r.signed_torque = mdl_torque;
        return r;
    endfunction

    function automatic pdpmc_pkg::t_result mk_result(logic [15:0] duty, logic dir, logic run,
                                                     logic [15:0] pos, logic [16:0] err,
                                                     logic [31:0] trq);
        pdpmc_pkg::t_result r;
        r.pwm_duty      = duty;
        r.reverse_dir   = dir;
        r.running       = run;
        r.position      = pos;
        r.last_err      = err;
        r.signed_torque = trq;
        return r;
    endfunction

    function automatic t_plan_row cfg_row(pdpmc_pkg::t_reg_idx idx, logic [15:0] value);
        t_plan_row r;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.value   = value;
        r.req     = pdpmc_pkg::REQ_DELTA;
        r.delta   = '0;
        r.typed   = 1'b0;
        r.exp_res = '0;
        return r;
    endfunction

    function automatic t_plan_row req_row(pdpmc_pkg::t_req req, logic [7:0] delta);
        t_plan_row r;
        r = cfg_row(pdpmc_pkg::REG_SETPOINT, '0);
        r.is_cfg = 1'b0;
        r.req    = req;
        r.delta  = delta;
        return r;
    endfunction

    function automatic t_plan_row typed_row(pdpmc_pkg::t_req req, logic [7:0] delta,
                                            pdpmc_pkg::t_result res);
        t_plan_row r;
        r = req_row(req, delta);
        r.typed   = 1'b1;
        r.exp_res = res;
        return r;
    endfunction

    // Offers one request, after a random gap unless in a burst, and records its expected result once taken.
    task automatic send_request(pdpmc_pkg::t_req req, logic [7:0] delta, bit burst,
                                bit use_typed, pdpmc_pkg::t_result typed_res);
        int                 gap;
        pdpmc_pkg::t_result predicted;
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= delta;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        predicted = step_controller(req, delta);
        expected_results.push_back(use_typed ? typed_res : predicted);
    endtask

    // Stops offering requests and waits until every outstanding result has arrived.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // APB write: setup phase, access phase, then an idle phase.
    task automatic cfg_write(pdpmc_pkg::t_reg_idx idx, logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            pdpmc_pkg::REG_SETPOINT:  mdl_cfg.setpoint  = value;
            pdpmc_pkg::REG_GAIN_P:    mdl_cfg.gain_p    = value;
            pdpmc_pkg::REG_GAIN_D:    mdl_cfg.gain_d    = value;
            pdpmc_pkg::REG_MIN_DRIVE: mdl_cfg.min_drive = value;
        endcase
        @(posedge i_clk);
    endtask

    // Main stimulus: reset, directed table, then randomized phases.
    initial begin
        pdpmc_pkg::t_req req;
        logic [7:0]  delta;
        logic [15:0] sp_val;
        logic [15:0] gp_val;
        logic [15:0] gd_val;
        logic [15:0] md_val;
        longint      offset;
        int          pick;
        int          item_no;

        plan = '{
            // A tick while stopped changes nothing.
            typed_row(pdpmc_pkg::REQ_TICK,  8'h55,
                      mk_result('0, 1'b0, 1'b0, 16'h0000, '0, '0)),
            typed_row(pdpmc_pkg::REQ_DELTA, 8'h7F,
                      mk_result('0, 1'b0, 1'b0, 16'h007F, '0, '0)),
            typed_row(pdpmc_pkg::REQ_DELTA, 8'h80,
                      mk_result('0, 1'b0, 1'b0, 16'hFFFF, '0, '0)),
            // Position reset ignores the delta field.
            typed_row(pdpmc_pkg::REQ_ZERO,  8'hAA,
                      mk_result('0, 1'b0, 1'b0, 16'h0000, '0, '0)),
            typed_row(pdpmc_pkg::REQ_START, 8'h00,
                      mk_result('0, 1'b0, 1'b1, 16'h0000, '0, '0)),
            // Start while already running keeps running.
            typed_row(pdpmc_pkg::REQ_START, 8'h33,
                      mk_result('0, 1'b0, 1'b1, 16'h0000, '0, '0)),
            // Zero error stops the run, and the minimum drive does not apply.
            typed_row(pdpmc_pkg::REQ_TICK,  8'h00,
                      mk_result('0, 1'b0, 1'b0, 16'h0000, '0, '0)),
            cfg_row(pdpmc_pkg::REG_SETPOINT,  16'h8000),
            cfg_row(pdpmc_pkg::REG_GAIN_P,    16'h8000),
            cfg_row(pdpmc_pkg::REG_GAIN_D,    16'h4000),
            cfg_row(pdpmc_pkg::REG_MIN_DRIVE, 16'hFFFF),
            req_row(pdpmc_pkg::REQ_START, 8'hFF),
            req_row(pdpmc_pkg::REQ_TICK,  8'h00),
            req_row(pdpmc_pkg::REQ_DELTA, 8'hFF),
            cfg_row(pdpmc_pkg::REG_SETPOINT,  16'h7FFF),
            // Torque wraps to the most negative value: reverse at full duty.
            typed_row(pdpmc_pkg::REQ_TICK, 8'h00,
                      mk_result(16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 17'h08000, 32'h8000_0000)),
            // Position reset keeps the run, duty and error.
            req_row(pdpmc_pkg::REQ_ZERO, 8'h01),
            cfg_row(pdpmc_pkg::REG_GAIN_P,    16'h0000),
            cfg_row(pdpmc_pkg::REG_GAIN_D,    16'h0001),
            cfg_row(pdpmc_pkg::REG_MIN_DRIVE, pdpmc_pkg::MIN_DRIVE_RESET),
            // A tiny torque is raised to the minimum drive.
            req_row(pdpmc_pkg::REQ_TICK, 8'h00),
            cfg_row(pdpmc_pkg::REG_MIN_DRIVE, 16'h0000),
            req_row(pdpmc_pkg::REQ_TICK, 8'h00),
            req_row(pdpmc_pkg::REQ_DELTA, 8'h7F)
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                wait_idle();
                cfg_write(plan[i].reg_idx, plan[i].value);
            end else begin
                send_request(plan[i].req, plan[i].delta, 1'b0, plan[i].typed,
                             plan[i].exp_res);
            end
        end

        // Random phases, each with its own register settings; the first two are extremes.
        item_no = 0;
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: begin
                    sp_val = 16'h7FFF; gp_val = 16'h7FFF; gd_val = 16'h7FFF; md_val = 16'hFFFF;
                end
                1: begin
                    sp_val = 16'h8000; gp_val = 16'h8000; gd_val = 16'h8000; md_val = 16'h0000;
                end
                default: begin
                    sp_val = 16'($urandom_range(0, 511)) - 16'd256;
                    gp_val = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 63)) - 16'd32;
                    gd_val = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 63)) - 16'd32;
                    md_val = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 3000));
                end
            endcase
            wait_idle();
            cfg_write(pdpmc_pkg::REG_SETPOINT, sp_val);
            cfg_write(pdpmc_pkg::REG_GAIN_P, gp_val);
            cfg_write(pdpmc_pkg::REG_GAIN_D, gd_val);
            cfg_write(pdpmc_pkg::REG_MIN_DRIVE, md_val);

            for (int n = 0; n < 100; n++) begin
                pick  = $urandom_range(0, 99);
                delta = 8'($urandom);
                if (pick < 40) begin
                    req = pdpmc_pkg::REQ_DELTA;
                    // Half of the deltas steer toward the setpoint so runs can finish.
                    if ($urandom_range(0, 1) == 1) begin
                        offset = longint'(mdl_cfg.setpoint) - longint'(mdl_pos);
                        if (offset > 127)
                            offset = 127;
                        if (offset < -128)
                            offset = -128;
                        delta = offset[7:0];
                    end
                end else if (pick < 80) begin
                    req = pdpmc_pkg::REQ_TICK;
                end else if (pick < 92) begin
                    req = pdpmc_pkg::REQ_START;
                end else begin
                    req = pdpmc_pkg::REQ_ZERO;
                end
                send_request(req, delta, ((item_no / 50) % 4) == 3, 1'b0, '0);
                item_no++;
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Result receiver with random stalls, bursts without stalls and one long hold-off.
    initial begin
        int stall;
        int taken;
        taken = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken == 250)
                stall = 120;
            else if (((taken / 40) % 5) == 2)
                stall = 0;
            else
                stall = $urandom_range(0, 9);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!m_axis_tvalid);
            taken++;
        end
    end

    // Compare every result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        pdpmc_pkg::t_result got;
        pdpmc_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = pdpmc_pkg::t_result'(m_axis_tdata[pdpmc_pkg::RESULT_W-1:0]);
            if (expected_results.size() == 0) begin
                $display("%0t: result with no request outstanding: %h", $time, got);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.pwm_duty !== want.pwm_duty) begin
                    $display("%0t: pwm_duty expected %0d got %0d",
                             $time, want.pwm_duty, got.pwm_duty);
                    mismatch_count++;
                end
                if (got.reverse_dir !== want.reverse_dir) begin
                    $display("%0t: reverse_dir expected %0d got %0d",
                             $time, want.reverse_dir, got.reverse_dir);
                    mismatch_count++;
                end
                if (got.running !== want.running) begin
                    $display("%0t: running expected %0d got %0d",
                             $time, want.running, got.running);
                    mismatch_count++;
                end
                if (got.position !== want.position) begin
                    $display("%0t: position expected %0d got %0d",
                             $time, want.position, got.position);
                    mismatch_count++;
                end
                if (got.last_err !== want.last_err) begin
                    $display("%0t: last_err expected %0d got %0d",
                             $time, want.last_err, got.last_err);
                    mismatch_count++;
                end
                if (got.signed_torque !== want.signed_torque) begin
                    $display("%0t: signed_torque expected %h got %h",
                             $time, want.signed_torque, got.signed_torque);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
